### hdl/dfe_pkg.sv
`default_nettype none
package dfe_pkg;

  localparam int DEF_MAX_DELIM_BYTES = 8;
  localparam int DEF_INDEX_BITS = 16;

  localparam int DELIM_REG_BITS = 64;
  localparam int LEN_REG_BITS = 4;
  localparam int INDEX_REG_BITS = 16;
  localparam int DATA_BITS = 64;
  localparam int ADDR_BITS = 5;

  localparam logic [1:0] REG_DELIM_BYTES = 2'd0;
  localparam logic [1:0] REG_DELIM_LENGTH = 2'd1;
  localparam logic [1:0] REG_FIELD_INDEX = 2'd2;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_last;
  } text_word_t;

  typedef struct packed {
    logic [7:0] field_byte;
    logic       byte_valid;
    logic       string_done;
    logic       field_found;
    logic       run_last;
  } result_word_t;

  typedef struct packed {
    logic has_status;
    logic found;
  } burst_flags_t;

endpackage
`default_nettype wire

### hdl/dfe_regs.sv
`default_nettype none
module dfe_regs (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [dfe_pkg::ADDR_BITS-1:0]       paddr,
  input  wire logic [dfe_pkg::DATA_BITS-1:0]       pwdata,
  output logic      [dfe_pkg::DATA_BITS-1:0]       prdata,
  output logic      [dfe_pkg::DELIM_REG_BITS-1:0]  delim_bytes,
  output logic      [dfe_pkg::LEN_REG_BITS-1:0]    delim_len,
  output logic      [dfe_pkg::INDEX_REG_BITS-1:0]  field_index
);
  import dfe_pkg::*;

  logic       wr;
  logic [1:0] sel;

  assign wr  = psel && penable && pwrite;
  assign sel = paddr[4:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      delim_bytes <= DELIM_REG_BITS'(44);
      delim_len   <= LEN_REG_BITS'(1);
      field_index <= '0;
    end else if (wr) begin
      case (sel)
        REG_DELIM_BYTES:  delim_bytes <= pwdata[DELIM_REG_BITS-1:0];
        REG_DELIM_LENGTH: delim_len   <= pwdata[LEN_REG_BITS-1:0];
        REG_FIELD_INDEX:  field_index <= pwdata[INDEX_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_DELIM_BYTES:  prdata = DATA_BITS'(delim_bytes);
      REG_DELIM_LENGTH: prdata = DATA_BITS'(delim_len);
      REG_FIELD_INDEX:  prdata = DATA_BITS'(field_index);
      default:          prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

### hdl/dfe_core.sv
`default_nettype none
module dfe_core #(
  parameter int MAX_DELIM_BYTES = dfe_pkg::DEF_MAX_DELIM_BYTES,
  parameter int INDEX_BITS = dfe_pkg::DEF_INDEX_BITS,
  localparam int CW = $clog2(MAX_DELIM_BYTES + 1),
  localparam int PW = (MAX_DELIM_BYTES > 1) ? $clog2(MAX_DELIM_BYTES) : 1
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   accept,
  input  wire dfe_pkg::text_word_t                    word,
  input  wire logic [dfe_pkg::DELIM_REG_BITS-1:0]     delim_bytes,
  input  wire logic [dfe_pkg::LEN_REG_BITS-1:0]       delim_len,
  input  wire logic [dfe_pkg::INDEX_REG_BITS-1:0]     field_index,
  output logic      [MAX_DELIM_BYTES-1:0][7:0]        burst_win,
  output logic      [PW-1:0]                          burst_top,
  output logic      [CW-1:0]                          burst_count,
  output dfe_pkg::burst_flags_t                       burst_flags
);
  import dfe_pkg::*;

  logic [MAX_DELIM_BYTES-1:0][7:0] win;
  logic [CW-1:0]                   bsm;
  logic [INDEX_BITS:0]             fields_seen;
  logic                            seen_first;
  logic                            data_after_first;

  logic [MAX_DELIM_BYTES-1:0][7:0] win_next;
  logic [CW-1:0]                   bsm_next;
  logic [INDEX_BITS:0]             fields_seen_next;
  logic                            seen_first_next;
  logic                            data_after_first_next;

  logic [7:0][7:0]     dl;
  logic [LEN_REG_BITS-1:0] len4;
  logic [CW-1:0]       len;
  logic [CW:0]         cnt;
  logic [31:0]         fi32;
  logic [INDEX_BITS:0] idx;
  logic                matched;
  logic                emit;
  logic                flush_en;
  logic [CW-1:0]       p;
  logic [CW-1:0]       len_m1;

  assign dl   = delim_bytes;
  assign fi32 = {16'b0, field_index};
  assign idx  = {1'b0, fi32[INDEX_BITS-1:0]};

  always_comb begin
    if (delim_len == '0) begin
      len4 = LEN_REG_BITS'(1);
    end else if (delim_len > LEN_REG_BITS'(MAX_DELIM_BYTES)) begin
      len4 = LEN_REG_BITS'(MAX_DELIM_BYTES);
    end else begin
      len4 = delim_len;
    end
  end

  assign len    = CW'(len4);
  assign len_m1 = len - CW'(1);
  assign cnt    = {1'b0, bsm} + (CW+1)'(1);

  // shifted window, newest byte first
  always_comb begin
    win_next[0] = word.text_byte;
    for (int i = 1; i < MAX_DELIM_BYTES; i++) begin
      win_next[i] = win[i-1];
    end
  end

  always_comb begin
    logic       ok;
    logic [2:0] d_sel;
    ok = 1'b1;
    d_sel = '0;
    for (int i = 0; i < MAX_DELIM_BYTES; i++) begin
      d_sel = 3'(int'(len) - 1 - i);
      if (i < int'(len) && win_next[i] != dl[d_sel]) begin
        ok = 1'b0;
      end
    end
    matched = ok && (cnt >= {1'b0, len});
  end

  always_comb begin
    seen_first_next       = seen_first | matched;
    data_after_first_next = data_after_first | seen_first;
    if (matched && !(&fields_seen)) begin
      fields_seen_next = fields_seen + (INDEX_BITS+1)'(1);
    end else begin
      fields_seen_next = fields_seen;
    end
    if (matched) begin
      bsm_next = '0;
    end else if (cnt > (CW+1)'(MAX_DELIM_BYTES)) begin
      bsm_next = CW'(MAX_DELIM_BYTES);
    end else begin
      bsm_next = cnt[CW-1:0];
    end
  end

  assign emit     = !matched && (cnt >= {1'b0, len}) && (fields_seen == idx);
  assign flush_en = word.text_last && (fields_seen_next == idx);

  always_comb begin
    if (matched) begin
      p = '0;
    end else if (bsm_next > len_m1) begin
      p = len_m1;
    end else begin
      p = bsm_next;
    end
  end

  // emitted bytes are window entries burst_top down, burst_count of them
  always_comb begin
    burst_win = win_next;
    if (flush_en) begin
      burst_count = p + CW'(emit);
      burst_top   = PW'(burst_count - CW'(1));
    end else begin
      burst_count = CW'(emit);
      burst_top   = PW'(len_m1);
    end
    burst_flags.has_status = word.text_last;
    if (idx == '0) begin
      burst_flags.found = seen_first_next;
    end else begin
      burst_flags.found = seen_first_next && data_after_first_next
                          && (fields_seen_next >= idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win              <= '0;
      bsm              <= '0;
      fields_seen      <= '0;
      seen_first       <= 1'b0;
      data_after_first <= 1'b0;
    end else if (accept) begin
      if (word.text_last) begin
        win              <= '0;
        bsm              <= '0;
        fields_seen      <= '0;
        seen_first       <= 1'b0;
        data_after_first <= 1'b0;
      end else begin
        win              <= win_next;
        bsm              <= bsm_next;
        fields_seen      <= fields_seen_next;
        seen_first       <= seen_first_next;
        data_after_first <= data_after_first_next;
      end
    end
  end

endmodule
`default_nettype wire

### hdl/dfe_serial.sv
`default_nettype none
module dfe_serial #(
  parameter int MAX_DELIM_BYTES = dfe_pkg::DEF_MAX_DELIM_BYTES,
  localparam int CW = $clog2(MAX_DELIM_BYTES + 1),
  localparam int PW = (MAX_DELIM_BYTES > 1) ? $clog2(MAX_DELIM_BYTES) : 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              load_req,
  input  wire logic [MAX_DELIM_BYTES-1:0][7:0]   burst_win,
  input  wire logic [PW-1:0]                     burst_top,
  input  wire logic [CW-1:0]                     burst_count,
  input  wire dfe_pkg::burst_flags_t             burst_flags,
  output logic                                   can_load,
  output logic                                   result_valid,
  input  wire logic                              result_stall,
  output dfe_pkg::result_word_t                  result_word
);
  import dfe_pkg::*;

  logic [MAX_DELIM_BYTES-1:0][7:0] win;
  logic [PW-1:0]                   top;
  logic [CW-1:0]                   count;
  burst_flags_t                    flags;
  logic [CW-1:0]                   ptr;
  logic                            busy;

  logic [CW:0]   total;
  logic          at_end;
  logic          take;
  logic          load;
  logic [PW-1:0] sel;
  logic          is_byte;

  assign total   = {1'b0, count} + (CW+1)'(flags.has_status);
  assign at_end  = ({1'b0, ptr} + (CW+1)'(1)) == total;
  assign take    = busy && !result_stall;
  assign can_load = !busy || (take && at_end);
  assign load    = load_req && can_load
                   && (burst_count != '0 || burst_flags.has_status);
  assign is_byte = ptr < count;
  assign sel     = top - PW'(ptr);

  assign result_valid            = busy;
  assign result_word.field_byte  = is_byte ? win[sel] : 8'd0;
  assign result_word.byte_valid  = is_byte;
  assign result_word.string_done = !is_byte;
  assign result_word.field_found = !is_byte && flags.found;
  assign result_word.run_last    = at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ptr  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      ptr  <= '0;
    end else if (take) begin
      if (at_end) begin
        busy <= 1'b0;
      end
      ptr <= ptr + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      win   <= burst_win;
      top   <= burst_top;
      count <= burst_count;
      flags <= burst_flags;
    end
  end

endmodule
`default_nettype wire

### hdl/delimited_field_extractor.sv
// Streams text one byte per word and returns the bytes of the field selected
// by field_index, fields being split by a 1 to 8 byte delimiter matched
// leftmost without overlap. Bytes come out delayed by one fewer bytes than the
// delimiter length, before it is known whether the field exists; the status word
// closing each string carries field_found. A byte that yields at most one result
// is taken every cycle while result_stall is low. The final byte of a string
// yields up to MAX_DELIM_BYTES + 1 results, sent one per cycle by the output
// serializer while result_stall is low, and the input is stalled until the last
// of them leaves. Registers: delimiter bytes at 0x00 (first byte in bits 7:0),
// delimiter length at 0x08, field index at 0x10; write them only while no string
// is in flight.
`default_nettype none
module delimited_field_extractor #(
  parameter int MAX_DELIM_BYTES = dfe_pkg::DEF_MAX_DELIM_BYTES,
  parameter int INDEX_BITS = dfe_pkg::DEF_INDEX_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [dfe_pkg::ADDR_BITS-1:0]    paddr,
  input  wire logic [dfe_pkg::DATA_BITS-1:0]    pwdata,
  output logic      [dfe_pkg::DATA_BITS-1:0]    prdata,
  output logic                                  pready,
  input  wire logic                             text_valid,
  output logic                                  text_stall,
  input  wire dfe_pkg::text_word_t              text_word,
  output logic                                  result_valid,
  input  wire logic                             result_stall,
  output dfe_pkg::result_word_t                 result_word
);
  import dfe_pkg::*;

  localparam int CW = $clog2(MAX_DELIM_BYTES + 1);
  localparam int PW = (MAX_DELIM_BYTES > 1) ? $clog2(MAX_DELIM_BYTES) : 1;

  logic [DELIM_REG_BITS-1:0]       delim_bytes;
  logic [LEN_REG_BITS-1:0]         delim_len;
  logic [INDEX_REG_BITS-1:0]       field_index;
  logic [MAX_DELIM_BYTES-1:0][7:0] burst_win;
  logic [PW-1:0]                   burst_top;
  logic [CW-1:0]                   burst_count;
  burst_flags_t                    burst_flags;
  logic                            can_load;
  logic                            accept;

  assign pready     = 1'b1;
  assign text_stall = !can_load;
  assign accept     = text_valid && can_load;

  dfe_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .delim_bytes (delim_bytes),
    .delim_len   (delim_len),
    .field_index (field_index)
  );

  dfe_core #(
    .MAX_DELIM_BYTES (MAX_DELIM_BYTES),
    .INDEX_BITS      (INDEX_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .word        (text_word),
    .delim_bytes (delim_bytes),
    .delim_len   (delim_len),
    .field_index (field_index),
    .burst_win   (burst_win),
    .burst_top   (burst_top),
    .burst_count (burst_count),
    .burst_flags (burst_flags)
  );

  dfe_serial #(
    .MAX_DELIM_BYTES (MAX_DELIM_BYTES)
  ) u_serial (
    .clk          (clk),
    .rst          (rst),
    .load_req     (accept),
    .burst_win    (burst_win),
    .burst_top    (burst_top),
    .burst_count  (burst_count),
    .burst_flags  (burst_flags),
    .can_load     (can_load),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word)
  );

endmodule
`default_nettype wire
